// ===== design/tspw_pkg.sv =====
// ----------------------------------------------------------------------------
// tspw_pkg: shared types and constants of the tile stream to panel writer
// Payload structs for both channels, configuration set, queue entry layout,
// panel command codes and the RGB332 to RGB565 expansion.
// ----------------------------------------------------------------------------
package tspw_pkg;

    // Largest tile, in pixels, that is still drawn
    localparam int MAX_TILE_PIXELS = 1024;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Panel command codes
    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // Register map, one word per register
    typedef enum logic [1:0] {
        REG_OFFSET_X     = 2'd0,
        REG_OFFSET_Y     = 2'd1,
        REG_PANEL_WIDTH  = 2'd2,
        REG_PANEL_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [8:0] offset_x;
        logic [8:0] offset_y;
        logic [8:0] panel_width;
        logic [8:0] panel_height;
    } t_cfg;

    // Input transfer
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    // Output transfer
    typedef struct packed {
        logic [7:0] panel_byte;
        logic       is_command;
        logic       tile_done;
        logic       last;
    } t_out_item;

    // Work kind handed from front to back
    typedef enum logic {
        K_HDR = 1'b0,
        K_PIX = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pixel;
        logic        rgb332;
        logic        fin;
        logic [15:0] x1;
        logic [15:0] x2;
        logic [15:0] y1;
        logic [15:0] y2;
    } t_q_entry;

    // Expand one RGB332 pixel to RGB565 by bit replication
    function automatic logic [15:0] rgb332_to_565(input logic [7:0] px);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = {px[7:5], px[7:6]};
        g6 = {px[4:2], px[4:2]};
        b5 = {px[1:0], px[1:0], px[1]};
        return {r5, g6, b5};
    endfunction

endpackage

// ===== design/tile_stream_to_panel_writer.sv =====
// ----------------------------------------------------------------------------
// tile_stream_to_panel_writer: tile byte stream to panel bus converter
// Parses tile headers, emits window and memory-write commands, and passes
// pixel payload through with optional RGB332 to RGB565 expansion.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid, o_stall, i_data): one stream byte or a new
//   connection marker per transfer. Output channel (o_valid, i_stall,
//   o_data): one panel bus byte per transfer, flagged as command or data,
//   with tile_done on the final pixel byte of a tile and last on the final
//   byte caused by an input transfer.
//   Output bytes pass the classify stage, queue and output register.
//   Throughput: the back sequencer emits one byte per cycle while the
//   queue holds work and the receiver does not stall, so RGB565 payload
//   runs at one input byte per cycle; an RGB332 payload byte gives two
//   output bytes and a drawn header eleven. Header bytes, drained tiles
//   and heartbeats give no output and go at one per cycle unless the
//   classify stage waits on a full queue. Reset clears the parser,
//   queue and output register and loads the register defaults (offsets
//   0, panel 240 by 240). When the receiver stalls, the output holds;
//   the queue then fills and o_stall rises. Registers are to be written
//   over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tile_stream_to_panel_writer #(
    parameter int QUEUE_DEPTH = tspw_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tspw_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output tspw_pkg::t_out_item o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tspw_pkg::*;

    t_cfg      r_cfg;
    t_reg_idx  reg_idx;
    logic      cfg_wr;
    logic      q_full;
    logic      q_push;
    t_q_entry  q_in;
    logic      q_valid;
    t_q_entry  q_head;
    logic      q_pop;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x     <= 9'd0;
            r_cfg.offset_y     <= 9'd0;
            r_cfg.panel_width  <= 9'd240;
            r_cfg.panel_height <= 9'd240;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_OFFSET_X:     r_cfg.offset_x     <= pwdata[8:0];
                REG_OFFSET_Y:     r_cfg.offset_y     <= pwdata[8:0];
                REG_PANEL_WIDTH:  r_cfg.panel_width  <= pwdata[8:0];
                REG_PANEL_HEIGHT: r_cfg.panel_height <= pwdata[8:0];
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_OFFSET_X:     prdata = {23'd0, r_cfg.offset_x};
            REG_OFFSET_Y:     prdata = {23'd0, r_cfg.offset_y};
            REG_PANEL_WIDTH:  prdata = {23'd0, r_cfg.panel_width};
            REG_PANEL_HEIGHT: prdata = {23'd0, r_cfg.panel_height};
        endcase
    end

    tspw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    tspw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    tspw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

// ===== design/tspw_front.sv =====
// ----------------------------------------------------------------------------
// tspw_front: stream parser and tile classifier
// Collects the 8-byte tile header, checks size and bounds, counts payload
// bytes by row and column, and hands headers and pixels to the queue.
// ----------------------------------------------------------------------------
module tspw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tspw_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  tspw_pkg::t_in_item  i_data,
    output logic                o_stall,
    input  logic                i_q_full,
    output logic                o_push,
    output tspw_pkg::t_q_entry  o_entry
);
    import tspw_pkg::*;

    // Parser state
    logic [7:0]  r_hdr [7];
    logic [2:0]  r_hcnt;
    logic        r_in_pay;
    logic        r_rgb;
    logic [15:0] r_col;
    logic [15:0] r_row;
    logic [15:0] r_bpr_m1;
    logic        r_drain;

    // Classified item stage
    logic        r_s1_valid;
    t_kind       r_s1_kind;
    logic [7:0]  r_s1_byte;
    logic        r_s1_rgb;
    logic        r_s1_fin;
    logic [15:0] r_s1_x1;
    logic [15:0] r_s1_x2;
    logic [15:0] r_s1_y1;
    logic [15:0] r_s1_y2;
    logic [30:0] r_s1_px;
    logic        r_s1_oob;

    logic        accept;
    logic        drain_now;
    logic        needs_push;
    logic        s1_done;
    logic        n_s1_valid;
    logic [15:0] hx;
    logic [15:0] hy;
    logic [15:0] hrw;
    logic [15:0] hh;
    logic [14:0] hw;
    logic [30:0] hpx;
    logic [15:0] hx1;
    logic [15:0] hx2;
    logic [15:0] hy1;
    logic [15:0] hy2;
    logic        hoob;
    logic        hbeat;
    logic [15:0] hbpr_m1;
    logic        pfin;

    // Decode the header as it completes on the eighth byte
    always_comb begin
        hx      = {r_hdr[0], r_hdr[1]};
        hy      = {r_hdr[2], r_hdr[3]};
        hrw     = {r_hdr[4], r_hdr[5]};
        hh      = {r_hdr[6], i_data.data_byte};
        hw      = hrw[14:0];
        hbeat   = (hw == 15'd0) || (hh == 16'd0);
        hpx     = 31'(hw) * 31'(hh);
        hx1     = {7'd0, i_cfg.offset_x} + hx;
        hx2     = hx1 + {1'b0, hw} - 16'd1;
        hy1     = {7'd0, i_cfg.offset_y} + hy;
        hy2     = hy1 + hh - 16'd1;
        hoob    = (({1'b0, hx} + {2'b0, hw}) > {8'd0, i_cfg.panel_width}) ||
                  (({1'b0, hy} + {1'b0, hh}) > {8'd0, i_cfg.panel_height});
        hbpr_m1 = hrw[15] ? ({1'b0, hw} - 16'd1) : ({hw, 1'b0} - 16'd1);
        pfin    = (r_col == 16'd0) && (r_row == 16'd0);
    end

    // Resolve the classified item: drop drained work, else push it
    always_comb begin
        drain_now  = r_s1_oob || (r_s1_px > 31'(MAX_TILE_PIXELS));
        needs_push = (r_s1_kind == K_HDR) ? !drain_now : !r_drain;
        s1_done    = !needs_push || !i_q_full;
        o_push     = r_s1_valid && needs_push && !i_q_full;
        o_stall    = r_s1_valid && !s1_done;
        accept     = i_valid && !o_stall;
        // Keep a held item, else load a drawn header or payload byte, or empty
        n_s1_valid = (r_s1_valid && !s1_done) ||
                     (accept && !i_data.cmd &&
                      (r_in_pay || ((r_hcnt == 3'd7) && !hbeat)));

        o_entry.kind   = r_s1_kind;
        o_entry.pixel  = r_s1_byte;
        o_entry.rgb332 = r_s1_rgb;
        o_entry.fin    = r_s1_fin;
        o_entry.x1     = r_s1_x1;
        o_entry.x2     = r_s1_x2;
        o_entry.y1     = r_s1_y1;
        o_entry.y2     = r_s1_y2;
    end

    // Parser control and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt     <= '0;
            r_in_pay   <= 1'b0;
            r_rgb      <= 1'b0;
            r_drain    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            // Latch the drain decision as the header leaves the stage
            if (r_s1_valid && s1_done && (r_s1_kind == K_HDR)) begin
                r_drain <= drain_now;
            end
            if (accept) begin
                if (i_data.cmd) begin
                    r_hcnt   <= '0;
                    r_in_pay <= 1'b0;
                end else if (!r_in_pay) begin
                    if (r_hcnt != 3'd7) begin
                        r_hcnt <= r_hcnt + 3'd1;
                    end else begin
                        r_hcnt <= '0;
                        r_rgb  <= hrw[15];
                        if (!hbeat) begin
                            r_in_pay <= 1'b1;
                        end
                    end
                end else begin
                    if (pfin) begin
                        r_in_pay <= 1'b0;
                    end
                end
            end
        end
    end

    // Header bytes, row and column counters, stage payload
    always_ff @(posedge i_clk) begin
        if (accept && !i_data.cmd) begin
            if (!r_in_pay) begin
                if (r_hcnt != 3'd7) begin
                    r_hdr[r_hcnt] <= i_data.data_byte;
                end else begin
                    r_col     <= hbpr_m1;
                    r_row     <= hh - 16'd1;
                    r_bpr_m1  <= hbpr_m1;
                    r_s1_kind <= K_HDR;
                    r_s1_x1   <= hx1;
                    r_s1_x2   <= hx2;
                    r_s1_y1   <= hy1;
                    r_s1_y2   <= hy2;
                    r_s1_px   <= hpx;
                    r_s1_oob  <= hoob;
                end
            end else begin
                r_s1_kind <= K_PIX;
                r_s1_byte <= i_data.data_byte;
                r_s1_rgb  <= r_rgb;
                r_s1_fin  <= pfin;
                if (r_col == 16'd0) begin
                    r_col <= r_bpr_m1;
                    r_row <= r_row - 16'd1;
                end else begin
                    r_col <= r_col - 16'd1;
                end
            end
        end
    end

endmodule

// ===== design/tspw_queue.sv =====
// ----------------------------------------------------------------------------
// tspw_queue: short register queue between front and back
// First-in first-out store of classified work; push and pop can share a cycle.
// ----------------------------------------------------------------------------
module tspw_queue #(
    parameter int DEPTH = tspw_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tspw_pkg::t_q_entry  i_entry,
    output logic                o_full,
    output logic                o_valid,
    output tspw_pkg::t_q_entry  o_head,
    input  logic                i_pop
);
    import tspw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_entry        r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== design/tspw_back.sv =====
// ----------------------------------------------------------------------------
// tspw_back: panel byte sequencer
// Expands each queued header into eleven command and address bytes and each
// pixel into one or two data bytes, through a registered output stage.
// ----------------------------------------------------------------------------
module tspw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tspw_pkg::t_q_entry  i_head,
    output logic                o_pop,
    output logic                o_valid,
    output tspw_pkg::t_out_item o_data,
    input  logic                i_stall
);
    import tspw_pkg::*;

    logic [3:0]  r_step;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [3:0]  last_step;
    logic        at_last;
    logic        out_free;
    logic        emit;
    logic [15:0] c565;

    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = i_q_valid && out_free;
    assign o_pop    = emit && at_last;

    // Choose the byte for the current step of the head entry
    always_comb begin
        c565 = rgb332_to_565(i_head.pixel);
        if (i_head.kind == K_HDR) begin
            last_step = 4'd10;
        end else if (i_head.rgb332) begin
            last_step = 4'd1;
        end else begin
            last_step = 4'd0;
        end
        at_last = (r_step == last_step);

        n_out.is_command = 1'b0;
        n_out.tile_done  = 1'b0;
        n_out.last       = at_last;
        n_out.panel_byte = i_head.pixel;
        if (i_head.kind == K_HDR) begin
            case (r_step)
                4'd0: begin
                    n_out.panel_byte = CMD_COL_SET;
                    n_out.is_command = 1'b1;
                end
                4'd1: n_out.panel_byte = i_head.x1[15:8];
                4'd2: n_out.panel_byte = i_head.x1[7:0];
                4'd3: n_out.panel_byte = i_head.x2[15:8];
                4'd4: n_out.panel_byte = i_head.x2[7:0];
                4'd5: begin
                    n_out.panel_byte = CMD_ROW_SET;
                    n_out.is_command = 1'b1;
                end
                4'd6: n_out.panel_byte = i_head.y1[15:8];
                4'd7: n_out.panel_byte = i_head.y1[7:0];
                4'd8: n_out.panel_byte = i_head.y2[15:8];
                4'd9: n_out.panel_byte = i_head.y2[7:0];
                default: begin
                    n_out.panel_byte = CMD_MEM_WRITE;
                    n_out.is_command = 1'b1;
                end
            endcase
        end else begin
            if (i_head.rgb332) begin
                n_out.panel_byte = (r_step == 4'd0) ? c565[15:8] : c565[7:0];
            end
            n_out.tile_done = i_head.fin && at_last;
        end
    end

    // Step through the head entry and hold the output while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_q_valid;
            if (emit) begin
                r_step <= at_last ? 4'd0 : r_step + 4'd1;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/tspw_checker.sv =====
// ----------------------------------------------------------------------------
// tspw_checker: port-level checks of the tile stream to panel writer
// Watches the output channel for held transfers and consistent flags.
// ----------------------------------------------------------------------------
module tspw_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_valid,
    input  logic                i_stall,
    input  tspw_pkg::t_out_item o_data
);
    import tspw_pkg::*;

    // Hold a stalled output transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output transfer changed while stalled");

    // Close a tile only on the last byte of its input
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.tile_done |-> o_data.last && !o_data.is_command)
        else $error("tile_done without last");

    // Send only known panel commands
    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_command |->
            (o_data.panel_byte == CMD_COL_SET) ||
            (o_data.panel_byte == CMD_ROW_SET) ||
            (o_data.panel_byte == CMD_MEM_WRITE))
        else $error("unknown command byte");

    // End a header burst on the memory-write command and only there
    a_mem_write_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_command |->
            (o_data.last == (o_data.panel_byte == CMD_MEM_WRITE)))
        else $error("header burst ends out of place");

endmodule

bind tile_stream_to_panel_writer tspw_checker u_tspw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
